// ===== rtl/core/lagrange_basis_evaluator_macros.svh =====
// assertion helpers of the basis evaluator, included by its top rtl file
`ifndef LAGRANGE_BASIS_EVALUATOR_MACROS_SVH
`define LAGRANGE_BASIS_EVALUATOR_MACROS_SVH

// same-cycle implication on the module clock, off during reset
`define LBE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on the module clock, off during reset
`define LBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_pkg
// widths, reset values, packet type and fixed point helpers of the evaluator
// ----------------------------------------------------------------------------
package lbe_pkg;

  localparam int unsigned CoordW   = 18;  // signed Q3.14 coordinate
  localparam int unsigned DiffW    = 19;  // difference of two coordinates
  localparam int unsigned DvdW     = 35;  // rounded dividend magnitude
  localparam int unsigned ResW     = 32;  // signed Q15.16 result
  localparam int unsigned SumW     = 35;  // exact sum of up to seven terms
  localparam int unsigned FracW    = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned IndexW   = 3;
  localparam int unsigned MaxNodes = 8;

  localparam logic signed [ResW-1:0] One      = 32'sd65536;
  localparam logic [DvdW-1:0]        RecipNum = 35'd1073741824;
  localparam logic signed [63:0]     ResMax   = 64'sd2147483647;
  localparam logic signed [63:0]     ResMin   = -64'sd2147483648;

  localparam logic signed [CoordW-1:0] NodeReset [MaxNodes] = '{
    -18'sd16384, -18'sd5461, 18'sd5461, 18'sd16384, 18'sd0, 18'sd0, 18'sd0, 18'sd0
  };

  // control that travels with one packet (one node of one transaction)
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [IndexW-1:0] idx;
  } meta_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [ResW-1:0] sat_res(input logic signed [63:0] v);
    logic signed [ResW-1:0] r;
    if (v > ResMax) begin
      r = ResMax[ResW-1:0];
    end else if (v < ResMin) begin
      r = ResMin[ResW-1:0];
    end else begin
      r = v[ResW-1:0];
    end
    return r;
  endfunction

  // q16 product, round half away from zero, saturated
  function automatic logic signed [ResW-1:0] mul_q16(input logic signed [ResW-1:0] a,
                                                     input logic signed [ResW-1:0] b);
    logic signed [63:0] p;
    logic [63:0]        mag;
    logic [63:0]        q;
    p   = 64'(a) * 64'(b);
    mag = p[63] ? 64'(-p) : 64'(p);
    q   = (mag + 64'd32768) >> FracW;
    return sat_res(p[63] ? -$signed(q) : $signed(q));
  endfunction

endpackage

// ===== rtl/core/lbe_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_div_cell
// one restoring step of an unsigned divider, one quotient bit per cell
// ----------------------------------------------------------------------------
module lbe_div_cell (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [lbe_pkg::DiffW-1:0]    rem_i,
  input  logic [lbe_pkg::DvdW-1:0]     a_i,
  input  logic [lbe_pkg::DiffW-1:0]    dsr_i,
  input  logic                         neg_i,
  output logic [lbe_pkg::DiffW-1:0]    rem_o,
  output logic [lbe_pkg::DvdW-1:0]     a_o,
  output logic [lbe_pkg::DiffW-1:0]    dsr_o,
  output logic                         neg_o
);

  logic [lbe_pkg::DiffW:0] trial;
  logic                    fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem_i, a_i[lbe_pkg::DvdW-1]};
  assign fits  = trial >= {1'b0, dsr_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= fits ? lbe_pkg::DiffW'(trial - {1'b0, dsr_i}) : lbe_pkg::DiffW'(trial);
      a_o   <= {a_i[lbe_pkg::DvdW-2:0], fits};
      dsr_o <= dsr_i;
      neg_o <= neg_i;
    end
  end

endmodule

// ===== rtl/core/lbe_mul_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbe_mul_cell
// one node position of the product chain: scales value and slope terms
// ----------------------------------------------------------------------------
module lbe_mul_cell #(
  parameter int unsigned NODES = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [lbe_pkg::IndexW-1:0]        pos_i,
  input  lbe_pkg::meta_t                    meta_i,
  input  logic signed [lbe_pkg::ResW-1:0]   val_i,
  input  logic signed [lbe_pkg::ResW-1:0]   acc_i [NODES],
  input  logic signed [lbe_pkg::ResW-1:0]   r_i   [NODES],
  output lbe_pkg::meta_t                    meta_o,
  output logic signed [lbe_pkg::ResW-1:0]   val_o,
  output logic signed [lbe_pkg::ResW-1:0]   acc_o [NODES],
  output logic signed [lbe_pkg::ResW-1:0]   r_o   [NODES]
);

  logic active;

  // the factor of a node with itself is skipped
  assign active = meta_i.idx != pos_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_o <= '0;
    end else if (en_i) begin
      meta_o <= meta_i;
    end
  end

  // value lane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_o <= active ? lbe_pkg::mul_q16(val_i, r_i[0]) : val_i;
    end
  end

  // slope term lanes, the lane of this node takes no factor; factors shift down
  for (genvar k = 0; k < NODES; k++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_o[k] <= (active && lbe_pkg::IndexW'(k) != pos_i) ?
                    lbe_pkg::mul_q16(acc_i[k], r_i[0]) : acc_i[k];
        r_o[k]   <= (k < NODES - 1) ? r_i[(k + 1) % NODES] : r_i[k];
      end
    end
  end

endmodule

// ===== rtl/core/lagrange_basis_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagrange_basis_evaluator
// lagrange basis values and slopes at one coordinate, one result per node
// ----------------------------------------------------------------------------
// Usage: a transaction on the in channel carries xi (signed Q3.14). For it
// the out channel delivers NODES transactions, node 0 first, each with the
// basis value and slope (signed Q15.16, saturated); last marks node NODES-1.
// node_error is set, with zero value and slope, when two used nodes match.
// Node coordinates are written on the cfg port; the user must write them only
// while the block is idle, the block itself does not enforce it.
// Path: after the input holding register, a packet passes 1 entry stage, 35
// divider cells, 1 convert stage, NODES product cells and 1 output stage.
// Throughput: one packet per node enters the pipeline each cycle and the out
// channel takes one result per cycle, while no result waits.
// Reset: node registers take their default coordinates, the pipeline empties.
// Stall: while a result waits, the whole pipeline holds; the input holding
// register still takes a next transaction when it holds none.
// ----------------------------------------------------------------------------
`include "lagrange_basis_evaluator_macros.svh"

module lagrange_basis_evaluator #(
  parameter int unsigned NODES = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lbe_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic signed [lbe_pkg::CoordW-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [lbe_pkg::CoordW-1:0]   xi_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lbe_pkg::IndexW-1:0]          node_index_o,
  output logic signed [lbe_pkg::ResW-1:0]     shape_value_o,
  output logic signed [lbe_pkg::ResW-1:0]     shape_slope_o,
  output logic                                node_error_o,
  output logic                                last_o
);

  localparam int unsigned IW        = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned DivStages = lbe_pkg::DvdW;

  // node registers
  logic signed [lbe_pkg::CoordW-1:0] node_q [NODES];

  for (genvar n = 0; n < NODES; n++) begin : g_node
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        node_q[n] <= lbe_pkg::NodeReset[n];
      end else if (cfg_we_i && cfg_index_i == lbe_pkg::CfgIdxW'(n)) begin
        node_q[n] <= cfg_data_i;
      end
    end
  end

  // coincident node check
  logic err_d, err_q;

  always_comb begin
    err_d = 1'b0;
    for (int a = 0; a < NODES; a++) begin
      for (int b = a + 1; b < NODES; b++) begin
        if (node_q[a] == node_q[b]) begin
          err_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= 1'b0;
    end else begin
      err_q <= err_d;
    end
  end

  // input holding register, issues one packet per node
  logic                              adv, emit, at_last, accept;
  logic                              hold_q;
  logic signed [lbe_pkg::CoordW-1:0] x_q;
  logic [IW-1:0]                     idx_q;
  logic                              out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign emit       = hold_q && adv;
  assign at_last    = idx_q == IW'(NODES - 1);
  assign in_ready_o = !hold_q || (adv && at_last);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
      idx_q  <= '0;
    end else if (accept) begin
      hold_q <= 1'b1;
      idx_q  <= '0;
    end else if (emit && at_last) begin
      hold_q <= 1'b0;
    end else if (emit) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= xi_i;
    end
  end

  // entry stage: signed operands to rounded unsigned dividends
  lbe_pkg::meta_t               ent_meta_q;
  logic [lbe_pkg::DvdW-1:0]     ent_rd_q [NODES];
  logic [lbe_pkg::DvdW-1:0]     ent_cd_q [NODES];
  logic [lbe_pkg::DiffW-1:0]    ent_dsr_q [NODES];
  logic                         ent_rneg_q [NODES];
  logic                         ent_cneg_q [NODES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_meta_q <= '0;
    end else if (adv) begin
      ent_meta_q.valid <= emit;
      ent_meta_q.last  <= at_last;
      ent_meta_q.idx   <= lbe_pkg::IndexW'(idx_q);
    end
  end

  for (genvar j = 0; j < NODES; j++) begin : g_entry
    logic signed [lbe_pkg::DiffW-1:0] num_s, den_s;
    logic [lbe_pkg::DiffW-1:0]        num_mag, den_mag;

    assign num_s   = lbe_pkg::DiffW'(x_q) - lbe_pkg::DiffW'(node_q[j]);
    assign den_s   = lbe_pkg::DiffW'(node_q[idx_q]) - lbe_pkg::DiffW'(node_q[j]);
    assign num_mag = num_s[lbe_pkg::DiffW-1] ? lbe_pkg::DiffW'(-num_s) : lbe_pkg::DiffW'(num_s);
    assign den_mag = den_s[lbe_pkg::DiffW-1] ? lbe_pkg::DiffW'(-den_s) : lbe_pkg::DiffW'(den_s);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ent_rd_q[j]   <= {num_mag, lbe_pkg::FracW'(0)} + lbe_pkg::DvdW'(den_mag >> 1);
        ent_cd_q[j]   <= lbe_pkg::RecipNum + lbe_pkg::DvdW'(den_mag >> 1);
        ent_dsr_q[j]  <= den_mag;
        ent_rneg_q[j] <= num_s[lbe_pkg::DiffW-1] ^ den_s[lbe_pkg::DiffW-1];
        ent_cneg_q[j] <= den_s[lbe_pkg::DiffW-1];
      end
    end
  end

  // divider chains: factor lane and reciprocal lane per node
  lbe_pkg::meta_t            dmeta [DivStages+1];
  logic [lbe_pkg::DiffW-1:0] r_rem [DivStages+1][NODES];
  logic [lbe_pkg::DvdW-1:0]  r_a   [DivStages+1][NODES];
  logic [lbe_pkg::DiffW-1:0] r_dsr [DivStages+1][NODES];
  logic                      r_neg [DivStages+1][NODES];
  logic [lbe_pkg::DiffW-1:0] c_rem [DivStages+1][NODES];
  logic [lbe_pkg::DvdW-1:0]  c_a   [DivStages+1][NODES];
  logic [lbe_pkg::DiffW-1:0] c_dsr [DivStages+1][NODES];
  logic                      c_neg [DivStages+1][NODES];

  assign dmeta[0] = ent_meta_q;

  for (genvar j = 0; j < NODES; j++) begin : g_div_in
    assign r_rem[0][j] = '0;
    assign r_a[0][j]   = ent_rd_q[j];
    assign r_dsr[0][j] = ent_dsr_q[j];
    assign r_neg[0][j] = ent_rneg_q[j];
    assign c_rem[0][j] = '0;
    assign c_a[0][j]   = ent_cd_q[j];
    assign c_dsr[0][j] = ent_dsr_q[j];
    assign c_neg[0][j] = ent_cneg_q[j];
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dmeta[s+1] <= '0;
      end else if (adv) begin
        dmeta[s+1] <= dmeta[s];
      end
    end

    for (genvar j = 0; j < NODES; j++) begin : g_lane
      lbe_div_cell u_rdiv (
        .clk_i (clk_i),
        .en_i  (adv),
        .rem_i (r_rem[s][j]),
        .a_i   (r_a[s][j]),
        .dsr_i (r_dsr[s][j]),
        .neg_i (r_neg[s][j]),
        .rem_o (r_rem[s+1][j]),
        .a_o   (r_a[s+1][j]),
        .dsr_o (r_dsr[s+1][j]),
        .neg_o (r_neg[s+1][j])
      );

      lbe_div_cell u_cdiv (
        .clk_i (clk_i),
        .en_i  (adv),
        .rem_i (c_rem[s][j]),
        .a_i   (c_a[s][j]),
        .dsr_i (c_dsr[s][j]),
        .neg_i (c_neg[s][j]),
        .rem_o (c_rem[s+1][j]),
        .a_o   (c_a[s+1][j]),
        .dsr_o (c_dsr[s+1][j]),
        .neg_o (c_neg[s+1][j])
      );
    end
  end

  // convert stage: apply signs, saturate the factor quotients
  lbe_pkg::meta_t                  cv_meta_q;
  logic signed [lbe_pkg::ResW-1:0] cv_r_q   [NODES];
  logic signed [lbe_pkg::ResW-1:0] cv_acc_q [NODES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_meta_q <= '0;
    end else if (adv) begin
      cv_meta_q <= dmeta[DivStages];
    end
  end

  for (genvar j = 0; j < NODES; j++) begin : g_conv
    logic signed [lbe_pkg::DvdW:0]   rs;
    logic signed [lbe_pkg::ResW-1:0] cs;

    assign rs = r_neg[DivStages][j] ? -$signed({1'b0, r_a[DivStages][j]})
                                    :  $signed({1'b0, r_a[DivStages][j]});
    assign cs = $signed(lbe_pkg::ResW'(c_a[DivStages][j]));

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cv_r_q[j]   <= lbe_pkg::sat_res(64'(rs));
        cv_acc_q[j] <= c_neg[DivStages][j] ? -cs : cs;
      end
    end
  end

  // product chain, one cell per node position
  lbe_pkg::meta_t                  m_meta [NODES+1];
  logic signed [lbe_pkg::ResW-1:0] m_val  [NODES+1];
  logic signed [lbe_pkg::ResW-1:0] m_acc  [NODES+1][NODES];
  logic signed [lbe_pkg::ResW-1:0] m_r    [NODES+1][NODES];

  assign m_meta[0] = cv_meta_q;
  assign m_val[0]  = lbe_pkg::One;
  assign m_acc[0]  = cv_acc_q;
  assign m_r[0]    = cv_r_q;

  for (genvar j = 0; j < NODES; j++) begin : g_cell
    lbe_mul_cell #(
      .NODES (NODES)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .pos_i  (lbe_pkg::IndexW'(j)),
      .meta_i (m_meta[j]),
      .val_i  (m_val[j]),
      .acc_i  (m_acc[j]),
      .r_i    (m_r[j]),
      .meta_o (m_meta[j+1]),
      .val_o  (m_val[j+1]),
      .acc_o  (m_acc[j+1]),
      .r_o    (m_r[j+1])
    );
  end

  // slope sum over the other nodes
  logic signed [lbe_pkg::SumW-1:0] sum;
  logic signed [lbe_pkg::ResW-1:0] slope_d;

  always_comb begin
    sum = '0;
    for (int k = 0; k < NODES; k++) begin
      if (lbe_pkg::IndexW'(k) != m_meta[NODES].idx) begin
        sum = sum + lbe_pkg::SumW'(m_acc[NODES][k]);
      end
    end
  end

  assign slope_d = lbe_pkg::sat_res(64'(sum));

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= m_meta[NODES].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      node_index_o  <= m_meta[NODES].idx;
      last_o        <= m_meta[NODES].last;
      node_error_o  <= err_q;
      shape_value_o <= err_q ? '0 : m_val[NODES];
      shape_slope_o <= err_q ? '0 : slope_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  `LBE_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, hold_q && idx_q == '0, "new transaction did not start at node zero")
  `LBE_ASSERT_NEXT(a_emit_enters, emit, ent_meta_q.valid, "issued packet missing from entry stage")
  `LBE_ASSERT_SAME(a_last_node, out_valid_o, last_o == (node_index_o == lbe_pkg::IndexW'(NODES - 1)), "last flag off the final node")
  `LBE_ASSERT_SAME(a_err_zero, out_valid_o && node_error_o, shape_value_o == '0 && shape_slope_o == '0, "error result not zeroed")

endmodule

// ===== test/lagrange_basis_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagrange_basis_checker
// watches the ports of the basis evaluator, predicts every node result of each
// accepted coordinate and compares the delivered results field by field
// ----------------------------------------------------------------------------
module lagrange_basis_checker #(
  parameter int unsigned NODES = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lbe_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic signed [lbe_pkg::CoordW-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [lbe_pkg::CoordW-1:0]   xi_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [lbe_pkg::IndexW-1:0]          node_index_i,
  input  logic signed [lbe_pkg::ResW-1:0]     shape_value_i,
  input  logic signed [lbe_pkg::ResW-1:0]     shape_slope_i,
  input  logic                                node_error_i,
  input  logic                                last_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);

  typedef struct {
    logic [lbe_pkg::IndexW-1:0] idx;
    logic signed [31:0]         value;
    logic signed [31:0]         slope;
    logic                       err;
    logic                       last;
  } basis_res_t;

  longint     node_coord [lbe_pkg::MaxNodes];
  basis_res_t basis_q [$];

  assign pending_o = basis_q.size();

  // n / d rounded to nearest, ties away from zero
  function automatic longint div_nearest(input longint n, input longint d);
    longint un, ud, q;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q  = (un + ud / 2) / ud;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint q16_mul(input longint a, input longint b);
    return clamp32(div_nearest(a * b, 65536));
  endfunction

  // expected results of all nodes for one coordinate
  task automatic predict_basis(input longint x);
    longint     factor [lbe_pkg::MaxNodes];
    longint     val, term, sum, slope;
    logic       coincide;
    basis_res_t r;
    coincide = 1'b0;
    for (int i = 0; i < NODES; i++)
      for (int j = i + 1; j < NODES; j++)
        if (node_coord[i] == node_coord[j]) coincide = 1'b1;
    for (int i = 0; i < NODES; i++) begin
      val = 0;
      sum = 0;
      if (!coincide) begin
        for (int j = 0; j < NODES; j++)
          factor[j] = (j == i) ? 65536 :
            clamp32(div_nearest((x - node_coord[j]) * 65536, node_coord[i] - node_coord[j]));
        val = 65536;
        for (int j = 0; j < NODES; j++)
          if (j != i) val = q16_mul(val, factor[j]);
        for (int k = 0; k < NODES; k++) begin
          if (k != i) begin
            term = clamp32(div_nearest(64'sd1 << 30, node_coord[i] - node_coord[k]));
            for (int j = 0; j < NODES; j++)
              if (j != i && j != k) term = q16_mul(term, factor[j]);
            sum += term;
          end
        end
      end
      slope   = clamp32(sum);
      r.idx   = i[lbe_pkg::IndexW-1:0];
      r.value = val[31:0];
      r.slope = slope[31:0];
      r.err   = coincide;
      r.last  = (i == NODES - 1);
      basis_q.push_back(r);
    end
  endtask

  // node registers, input prediction and output compare
  always @(posedge clk_i or negedge rst_ni) begin
    basis_res_t e;
    if (!rst_ni) begin
      for (int i = 0; i < lbe_pkg::MaxNodes; i++)
        node_coord[i] = longint'(lbe_pkg::NodeReset[i]);
      basis_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) node_coord[cfg_index_i] = longint'(cfg_data_i);
      if (in_valid_i && in_ready_i) predict_basis(longint'(xi_i));
      if (out_valid_i && out_ready_i) begin
        if (basis_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("ERROR: unexpected result node %0d value %0d slope %0d",
                     node_index_i, shape_value_i, shape_slope_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = basis_q.pop_front();
          if (e.idx !== node_index_i || e.value !== shape_value_i ||
              e.slope !== shape_slope_i || e.err !== node_error_i || e.last !== last_i) begin
            if (fail_count_o < 10)
              $display("ERROR: exp idx %0d val %0d slope %0d err %0b last %0b / got %0d %0d %0d %0b %0b",
                       e.idx, e.value, e.slope, e.err, e.last, node_index_i,
                       shape_value_i, shape_slope_i, node_error_i, last_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives coordinates and node settings into the basis evaluator with random
// gaps and back pressure; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned NODES     = 4;
  localparam int unsigned DRAIN     = 80;    // more than the pipeline depth
  localparam int unsigned WDOG_MAX  = 5000;

  typedef enum logic [2:0] {
    REG_NODE_0, REG_NODE_1, REG_NODE_2, REG_NODE_3,
    REG_NODE_4, REG_NODE_5, REG_NODE_6, REG_NODE_7
  } node_reg_e;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [lbe_pkg::CfgIdxW-1:0]        cfg_index_i;
  logic signed [lbe_pkg::CoordW-1:0]  cfg_data_i;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic signed [lbe_pkg::CoordW-1:0]  xi_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic [lbe_pkg::IndexW-1:0]         node_index_o;
  logic signed [lbe_pkg::ResW-1:0]    shape_value_o;
  logic signed [lbe_pkg::ResW-1:0]    shape_slope_o;
  logic                               node_error_o;
  logic                               last_o;
  int unsigned                        fail_count;
  int unsigned                        pending;
  logic                               no_idle;
  int unsigned                        quiet_cycles = 0;

  lagrange_basis_evaluator #(.NODES(NODES)) u_dut (.*);

  lagrange_basis_checker #(.NODES(NODES)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .xi_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .node_index_i(node_index_o), .shape_value_i(shape_value_o),
    .shape_slope_i(shape_slope_o), .node_error_i(node_error_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side back pressure
  always @(posedge clk_i) begin
    out_ready_i <= no_idle ? 1'b1 : ($urandom_range(99) >= 33);
  end

  // watchdog on cycles without any transaction or register write
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_MAX) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_nodes(input logic signed [17:0] coords [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= node_reg_e'(i);
      cfg_data_i  <= coords[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one coordinate transaction, with an optional gap in front
  task automatic send_xi(input logic signed [17:0] x);
    if (!no_idle && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    xi_i       <= x;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold off until the pipeline has delivered everything
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // random coordinates: full range, and close to some node
  task automatic random_burst(input int n, input logic signed [17:0] coords [8]);
    logic signed [17:0] x;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(1))
        x = 18'($urandom);
      else
        x = coords[$urandom_range(NODES - 1)] + 18'($signed($urandom_range(64)) - 32);
      send_xi(x);
    end
  endtask

  logic signed [17:0] cfg_set [8];
  logic signed [17:0] dir_x [13];

  initial begin
    no_idle      = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = REG_NODE_0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    xi_i         = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default nodes: range ends, nodes themselves and their neighbors
    dir_x = '{-18'sd131072, 18'sd131071, 18'sd0, -18'sd1, 18'sd1, -18'sd16384,
              -18'sd5461, 18'sd5461, 18'sd16384, -18'sd16383, 18'sd16385,
              -18'sd65536, 18'sd65536};
    foreach (dir_x[k]) send_xi(dir_x[k]);
    cfg_set = lbe_pkg::NodeReset;
    random_burst(50, cfg_set);
    drain();

    // extreme node coordinates, unused registers written too
    cfg_set = '{-18'sd131072, -18'sd1, 18'sd1, 18'sd131071,
                18'sd131071, -18'sd131072, 18'sd77, -18'sd5};
    write_nodes(cfg_set);
    send_xi(-18'sd131072);
    send_xi(18'sd131071);
    send_xi(18'sd0);
    random_burst(55, cfg_set);
    drain();

    // coincident nodes flag an error
    cfg_set = '{18'sd100, 18'sd200, 18'sd100, 18'sd300,
                18'sd1, 18'sd2, 18'sd3, 18'sd4};
    write_nodes(cfg_set);
    send_xi(18'sd100);
    random_burst(20, cfg_set);
    drain();

    // tightly packed nodes drive the chain into saturation, no idling here
    no_idle = 1'b1;
    cfg_set = '{18'sd0, 18'sd1, 18'sd2, 18'sd3, 18'sd0, 18'sd0, 18'sd0, 18'sd0};
    write_nodes(cfg_set);
    send_xi(-18'sd131072);
    send_xi(18'sd131071);
    random_burst(60, cfg_set);
    drain();
    no_idle = 1'b0;

    // random node sets, small spread ones may coincide
    for (int p = 0; p < 4; p++) begin
      foreach (cfg_set[i])
        cfg_set[i] = (p == 3) ? 18'($urandom_range(3)) : 18'($urandom);
      write_nodes(cfg_set);
      random_burst(40, cfg_set);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lbe_pkg.sv
rtl/core/lbe_div_cell.sv
rtl/core/lbe_mul_cell.sv
rtl/core/lagrange_basis_evaluator.sv
test/lagrange_basis_checker.sv
test/tb_top.sv
